@@ design/assert_macros.svh @@
// Assertion macros shared by the weld core.
// Needs signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define VWIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition that must never be true outside of reset.
`define VWIR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/vwir_pkg.sv @@
// Shared types for the vertex weld core.
// No dependencies.
`default_nettype none
package vwir_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_VERT  = 2'd1,
    OP_TRI   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_VERT = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic  ld_item;
    logic  pos_wr;
    logic  scan_vld;
    logic  scan_flush;
    logic  remap_rd;
    logic  remap_wr;
    logic  remap_src_q;
    logic  tri_shift;
    logic  emit;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic hit_vld;
    logic hit;
    logic out_free;
    logic tri_degen;
  } stat_t;

endpackage
`default_nettype wire

@@ design/vertex_weld_and_index_remap_core.sv @@
// Vertex weld core. A vertex that has k > 0 earlier vertices is compared with each,
// one stored position read per cycle into a four-stage distance pipeline, and is
// welded to the first one that matches; a vertex with no earlier vertex skips the scan.
// Triangles, error results and clears need no scan; a degenerate triangle emits nothing;
// a result that still waits in the output register holds the next one back.
// Synchronous reset empties the mesh and zeroes the weld distance; no store clearing.
`default_nettype none
`include "assert_macros.svh"
module vertex_weld_and_index_remap_core #(
  parameter int MAX_VERTS = 1024
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           cfg_valid,
  output logic          cfg_ready,
  input  wire  [30:0]   cfg_data,   // weld_distance
  input  wire           in_tvalid,
  output logic          in_tready,
  input  wire  [1:0]    in_tuser,   // op
  // vert_x, vert_y, vert_z, in_norm_x, in_norm_y, in_norm_z, idx_a, idx_b, idx_c
  input  wire  [175:0]  in_tdata,
  output logic          out_tvalid,
  input  wire           out_tready,
  output logic [1:0]    out_tuser,  // kind
  // new_index, out_x, out_y, out_z, out_norm_x, out_norm_y, out_norm_z, tri_a, tri_b, tri_c
  output logic [183:0]  out_tdata
);
  import vwir_pkg::*;

  localparam int IW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  cmd_t          cmd;
  stat_t         st;
  logic [IW-1:0] pos_addr, scan_addr, remap_addr, uniq, hit_tag;
  logic          tri_out, tri_ab_ne;

  assign cfg_ready = 1'b1;

  vwir_ctrl #(.MAX_VERTS(MAX_VERTS), .IW(IW), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_ia      (in_tdata[153:144]),
    .in_ib      (in_tdata[163:154]),
    .in_ic      (in_tdata[173:164]),
    .st         (st),
    .hit_tag    (hit_tag),
    .cmd        (cmd),
    .pos_addr   (pos_addr),
    .scan_addr  (scan_addr),
    .remap_addr (remap_addr),
    .uniq       (uniq)
  );

  vwir_dp #(.IW(IW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata[143:0]),
    .cmd        (cmd),
    .pos_addr   (pos_addr),
    .scan_addr  (scan_addr),
    .remap_addr (remap_addr),
    .uniq       (uniq),
    .st         (st),
    .hit_tag    (hit_tag),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  assign tri_out   = out_tvalid && (out_tuser == KIND_TRI);
  assign tri_ab_ne = (out_tdata[163:154] != out_tdata[173:164]) || (MAX_VERTS > 1024);

  `VWIR_ASSERT_IMP(a_emit_free, cmd.emit, st.out_free, "result issued into a full output register")
  `VWIR_ASSERT_NEVER(a_scan_idle, cmd.scan_vld && in_tready, "scan issued while taking items")
  `VWIR_ASSERT_IMP(a_tri_distinct, tri_out, tri_ab_ne, "degenerate triangle emitted")

endmodule
`default_nettype wire

@@ design/vwir_dp.sv @@
// Datapath of the weld core: stores, distance pipeline, output register.
// Depends on vwir_pkg.
`default_nettype none
module vwir_dp #(
  parameter int IW = 10
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire [30:0]             cfg_data,
  input  wire [143:0]            in_tdata,
  input  vwir_pkg::cmd_t         cmd,
  input  wire [IW-1:0]           pos_addr,
  input  wire [IW-1:0]           scan_addr,
  input  wire [IW-1:0]           remap_addr,
  input  wire [IW-1:0]           uniq,
  output vwir_pkg::stat_t        st,
  output logic [IW-1:0]          hit_tag,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [1:0]             out_tuser,
  output logic [183:0]           out_tdata
);
  import vwir_pkg::*;

  logic [95:0]   pos_mem [2**IW];
  logic [IW-1:0] remap_mem [2**IW];

  logic [30:0]   weld_r;
  logic [63:0]   limit_r;
  logic [95:0]   vpos_r;
  logic [47:0]   vnorm_r;
  logic [95:0]   pos_q_r;
  logic [IW-1:0] remap_q_r;
  logic [IW-1:0] ra_r, rb_r, rc_r;

  logic          v1_r, v2_r, v3_r, v4_r;
  logic [IW-1:0] t1_r, t2_r, t3_r, t4_r;
  logic [31:0]   ad_r [3];
  logic          ov2_r, ov3_r;
  logic [63:0]   sq_r [3];
  logic          hit_r;

  logic [32:0]   ad_nxt [3];
  logic [2:0]    ov_nxt;
  logic [63:0]   sum;

  logic          out_vld_r;
  logic [1:0]    out_kind_r;
  logic [183:0]  out_data_r;
  logic [183:0]  out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weld_r <= '0;
    end else if (cfg_we) begin
      weld_r <= cfg_data;
    end
    limit_r <= 64'(weld_r) * 64'(weld_r);
    if (cmd.ld_item) begin
      vpos_r  <= in_tdata[95:0];
      vnorm_r <= in_tdata[143:96];
    end
    if (cmd.pos_wr) begin
      pos_mem[pos_addr] <= in_tdata[95:0];
    end
    pos_q_r <= pos_mem[scan_addr];
    if (cmd.remap_wr) begin
      remap_mem[remap_addr] <= cmd.remap_src_q ? remap_q_r : uniq;
    end
    if (cmd.remap_rd) begin
      remap_q_r <= remap_mem[remap_addr];
    end
    if (cmd.tri_shift) begin
      rc_r <= remap_q_r;
      rb_r <= rc_r;
      ra_r <= rb_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [32:0] d;
      d = {vpos_r[32*k+31], vpos_r[32*k +: 32]} - {pos_q_r[32*k+31], pos_q_r[32*k +: 32]};
      ad_nxt[k] = d[32] ? (33'd0 - d) : d;
      ov_nxt[k] = ad_nxt[k][32] | (ad_nxt[k][31] & (|ad_nxt[k][30:0]));
    end
    sum = sq_r[0] + sq_r[1] + sq_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_vld & ~cmd.scan_flush;
      v2_r <= v1_r & ~cmd.scan_flush;
      v3_r <= v2_r & ~cmd.scan_flush;
      v4_r <= v3_r & ~cmd.scan_flush;
    end
    t1_r  <= scan_addr;
    t2_r  <= t1_r;
    t3_r  <= t2_r;
    t4_r  <= t3_r;
    ov2_r <= |ov_nxt;
    ov3_r <= ov2_r;
    for (int k = 0; k < 3; k++) begin
      ad_r[k] <= ad_nxt[k][31:0];
      sq_r[k] <= 64'(ad_r[k]) * 64'(ad_r[k]);
    end
    hit_r <= ~ov3_r & (sum <= limit_r);
  end

  assign st.hit_vld   = v4_r;
  assign st.hit       = hit_r;
  assign st.out_free  = ~out_vld_r | out_tready;
  assign st.tri_degen = (ra_r == rb_r) | (rb_r == rc_r) | (ra_r == rc_r);
  assign hit_tag      = t4_r;

  always_comb begin
    out_data_nxt = '0;
    case (cmd.kind)
      KIND_VERT: begin
        out_data_nxt[9:0]     = 10'(uniq);
        out_data_nxt[105:10]  = vpos_r;
        out_data_nxt[153:106] = vnorm_r;
      end
      KIND_TRI: begin
        out_data_nxt[163:154] = 10'(ra_r);
        out_data_nxt[173:164] = 10'(rb_r);
        out_data_nxt[183:174] = 10'(rc_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_kind_r <= cmd.kind;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

@@ design/vwir_ctrl.sv @@
// Controller of the weld core: mesh counters, scan sequencing, result issue.
// Depends on vwir_pkg.
`default_nettype none
module vwir_ctrl #(
  parameter int MAX_VERTS = 1024,
  parameter int IW = 10,
  parameter int CW = 11
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire [1:0]           in_op,
  input  wire [9:0]           in_ia,
  input  wire [9:0]           in_ib,
  input  wire [9:0]           in_ic,
  input  vwir_pkg::stat_t     st,
  input  wire [IW-1:0]        hit_tag,
  output vwir_pkg::cmd_t      cmd,
  output logic [IW-1:0]       pos_addr,
  output logic [IW-1:0]       scan_addr,
  output logic [IW-1:0]       remap_addr,
  output logic [IW-1:0]       uniq
);
  import vwir_pkg::*;

  localparam int XW = (CW > 10) ? CW : 10;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_HRD  = 7'b0000100,
    S_HWR  = 7'b0001000,
    S_NEWV = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_TRI  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] loaded_r, loaded_nxt;
  logic [CW-1:0] uniq_r, uniq_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] rcv_r, rcv_nxt;
  logic [IW-1:0] tag_r, tag_nxt;
  logic [IW-1:0] ia_r, ib_r, ic_r;
  logic [2:0]    tcnt_r, tcnt_nxt;
  kind_t         kind_r, kind_nxt;
  logic          acc;
  logic          idx_bad;

  assign acc     = in_tvalid & in_tready;
  assign idx_bad = (XW'(in_ia) >= XW'(loaded_r)) | (XW'(in_ib) >= XW'(loaded_r)) |
                   (XW'(in_ic) >= XW'(loaded_r));
  assign pos_addr = IW'(loaded_r);
  assign uniq     = IW'(uniq_r);

  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    uniq_nxt   = uniq_r;
    iss_nxt    = iss_r;
    rcv_nxt    = rcv_r;
    tag_nxt    = tag_r;
    tcnt_nxt   = tcnt_r;
    kind_nxt   = kind_r;
    cmd        = '0;
    in_tready  = 1'b0;
    scan_addr  = IW'(iss_r);
    remap_addr = IW'(loaded_r);
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (acc) begin
          unique case (op_t'(in_op))
            OP_CLEAR: begin
              loaded_nxt = '0;
              uniq_nxt   = '0;
            end
            OP_VERT: begin
              if (loaded_r == CW'(MAX_VERTS)) begin
                kind_nxt  = KIND_ERR;
                state_nxt = S_EMIT;
              end else begin
                cmd.ld_item = 1'b1;
                cmd.pos_wr  = 1'b1;
                iss_nxt     = '0;
                rcv_nxt     = '0;
                state_nxt   = (loaded_r == '0) ? S_NEWV : S_SCAN;
              end
            end
            OP_TRI: begin
              if (idx_bad) begin
                kind_nxt  = KIND_ERR;
                state_nxt = S_EMIT;
              end else begin
                tcnt_nxt  = '0;
                state_nxt = S_TRI;
              end
            end
            OP_NONE: ;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (st.hit_vld && st.hit) begin
          cmd.scan_flush = 1'b1;
          tag_nxt        = hit_tag;
          state_nxt      = S_HRD;
        end else begin
          if (iss_r < loaded_r) begin
            cmd.scan_vld = 1'b1;
            iss_nxt      = iss_r + CW'(1);
          end
          if (st.hit_vld) begin
            rcv_nxt = rcv_r + CW'(1);
            if (rcv_nxt == loaded_r) begin
              state_nxt = S_NEWV;
            end
          end
        end
      end
      S_HRD: begin
        cmd.remap_rd = 1'b1;
        remap_addr   = tag_r;
        state_nxt    = S_HWR;
      end
      S_HWR: begin
        cmd.remap_wr    = 1'b1;
        cmd.remap_src_q = 1'b1;
        loaded_nxt      = loaded_r + CW'(1);
        state_nxt       = S_IDLE;
      end
      S_NEWV: begin
        cmd.remap_wr = 1'b1;
        kind_nxt     = KIND_VERT;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        cmd.kind = kind_r;
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
          if (kind_r == KIND_VERT) begin
            loaded_nxt = loaded_r + CW'(1);
            uniq_nxt   = uniq_r + CW'(1);
          end
        end
      end
      S_TRI: begin
        case (tcnt_r)
          3'd0: remap_addr = ia_r;
          3'd1: remap_addr = ib_r;
          default: remap_addr = ic_r;
        endcase
        cmd.remap_rd  = (tcnt_r < 3'd3);
        cmd.tri_shift = (tcnt_r != 3'd0) && (tcnt_r < 3'd4);
        tcnt_nxt      = tcnt_r + 3'd1;
        if (tcnt_r == 3'd4) begin
          if (st.tri_degen) begin
            state_nxt = S_IDLE;
          end else begin
            kind_nxt  = KIND_TRI;
            state_nxt = S_EMIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      loaded_r <= '0;
      uniq_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      uniq_r   <= uniq_nxt;
    end
    iss_r  <= iss_nxt;
    rcv_r  <= rcv_nxt;
    tag_r  <= tag_nxt;
    tcnt_r <= tcnt_nxt;
    kind_r <= kind_nxt;
    if (acc) begin
      ia_r <= IW'(in_ia);
      ib_r <= IW'(in_ib);
      ic_r <= IW'(in_ic);
    end
  end

endmodule
`default_nettype wire

@@ tb/vertex_weld_and_index_remap_core_test.sv @@
// Self-checking test of the vertex weld core: directed and random meshes,
// weld distance settings, stalls on both sides. Needs vwir_pkg and the core.
`default_nettype none
module vertex_weld_and_index_remap_core_test;
  import vwir_pkg::*;

  localparam int MAX_VERTS = 1024;

  typedef struct packed {
    logic [9:0]  tri_c;
    logic [9:0]  tri_b;
    logic [9:0]  tri_a;
    logic [15:0] nz;
    logic [15:0] ny;
    logic [15:0] nx;
    logic [31:0] pz;
    logic [31:0] py;
    logic [31:0] px;
    logic [9:0]  new_index;
  } weld_out_t;

  typedef struct packed {
    kind_t     kind;
    weld_out_t body;
  } weld_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [30:0] cfg_data = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [175:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [1:0] out_tuser;
  logic [183:0] out_tdata;

  always #5 clk = ~clk;

  vertex_weld_and_index_remap_core #(.MAX_VERTS(MAX_VERTS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata)
  );

  // Predictor state.
  logic [31:0] mesh_pos [MAX_VERTS][3];
  logic [9:0]  mesh_remap [MAX_VERTS];
  int unsigned mesh_loaded;
  int unsigned mesh_unique;
  logic [30:0] weld_dist;

  weld_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  bit hold_off = 0;

  task automatic add_expected(weld_result_t r);
    expected_results = {expected_results, r};
  endtask

  function automatic bit near_enough(logic [31:0] a[3], logic [31:0] b[3]);
    longint unsigned total;
    longint unsigned lim;
    longint d;
    total = 0;
    lim = longint'(weld_dist) * longint'(weld_dist);
    for (int k = 0; k < 3; k++) begin
      d = longint'($signed(a[k])) - longint'($signed(b[k]));
      if (d < 0) d = -d;
      if (d > 64'h8000_0000) return 0;
      total += d * d;
    end
    return total <= lim;
  endfunction

  task automatic predict_weld(op_t op, logic [175:0] data);
    weld_result_t r;
    logic [31:0] p[3];
    logic [9:0] ia, ib, ic, a, b, c;
    r = '0;
    case (op)
      OP_CLEAR: begin
        mesh_loaded = 0;
        mesh_unique = 0;
      end
      OP_VERT: begin
        if (mesh_loaded >= MAX_VERTS) begin
          r.kind = KIND_ERR;
          add_expected(r);
        end else begin
          p[0] = data[31:0]; p[1] = data[63:32]; p[2] = data[95:64];
          mesh_pos[mesh_loaded] = p;
          for (int j = 0; j < mesh_loaded; j++)
            if (near_enough(p, mesh_pos[j])) begin
              mesh_remap[mesh_loaded] = mesh_remap[j];
              mesh_loaded++;
              return;
            end
          mesh_remap[mesh_loaded] = mesh_unique[9:0];
          mesh_loaded++;
          r.kind = KIND_VERT;
          r.body.new_index = mesh_unique[9:0];
          r.body.px = p[0]; r.body.py = p[1]; r.body.pz = p[2];
          r.body.nx = data[111:96]; r.body.ny = data[127:112]; r.body.nz = data[143:128];
          mesh_unique++;
          add_expected(r);
        end
      end
      OP_TRI: begin
        ia = data[153:144]; ib = data[163:154]; ic = data[173:164];
        if (ia >= mesh_loaded || ib >= mesh_loaded || ic >= mesh_loaded) begin
          r.kind = KIND_ERR;
          add_expected(r);
        end else begin
          a = mesh_remap[ia]; b = mesh_remap[ib]; c = mesh_remap[ic];
          if (a != b && b != c && a != c) begin
            r.kind = KIND_TRI;
            r.body.tri_a = a; r.body.tri_b = b; r.body.tri_c = c;
            add_expected(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  bit no_gaps = 0;

  // The item stays offered until a gap or a drain takes it down.
  task automatic send_item(op_t op, logic [175:0] data);
    int g;
    g = no_gaps ? 0 : gap_len();
    if (g != 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    predict_weld(op, data);
    @(negedge clk);
  endtask

  function automatic logic [175:0] vert_data(logic [31:0] x, y, z, logic [15:0] nx, ny, nz);
    return {2'b0, 30'($urandom), nz, ny, nx, z, y, x};
  endfunction

  function automatic logic [175:0] tri_data(logic [9:0] a, b, c);
    return {2'b0, c, b, a, 144'({$urandom, $urandom, $urandom, $urandom, $urandom})};
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (MAX_VERTS + 20) @(negedge clk);
  endtask

  task automatic write_weld_distance(logic [30:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    weld_dist = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    weld_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = kind_t'(out_tuser);
      got.body = out_tdata;
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result kind=%0d data=%h", $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind) begin
          $display("%0t kind expected %0d actual %0d", $time, want.kind, got.kind);
          errors++;
        end
        if (got.body.new_index != want.body.new_index || got.body.px != want.body.px ||
            got.body.py != want.body.py || got.body.pz != want.body.pz) begin
          $display("%0t index/position expected %h %h %h %h actual %h %h %h %h", $time,
                   want.body.new_index, want.body.px, want.body.py, want.body.pz,
                   got.body.new_index, got.body.px, got.body.py, got.body.pz);
          errors++;
        end
        if (got.body.nx != want.body.nx || got.body.ny != want.body.ny ||
            got.body.nz != want.body.nz) begin
          $display("%0t normal expected %h %h %h actual %h %h %h", $time,
                   want.body.nx, want.body.ny, want.body.nz,
                   got.body.nx, got.body.ny, got.body.nz);
          errors++;
        end
        if (got.body.tri_a != want.body.tri_a || got.body.tri_b != want.body.tri_b ||
            got.body.tri_c != want.body.tri_c) begin
          $display("%0t triangle expected %h %h %h actual %h %h %h", $time,
                   want.body.tri_a, want.body.tri_b, want.body.tri_c,
                   got.body.tri_a, got.body.tri_b, got.body.tri_c);
          errors++;
        end
      end
    end
  end

  // Receiver stalls.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 0;
      else if (no_gaps) out_tready <= 1;
      else begin
        g = gap_len();
        if (g == 0) out_tready <= 1;
        else begin
          out_tready <= 0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8)) - 4) <<< 14;
      default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic test_directed();
    send_item(OP_TRI, tri_data(0, 0, 0));
    send_item(OP_VERT, vert_data(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'h8000, 16'h7FFF, 0));
    send_item(OP_VERT, vert_data(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                 16'h7FFF, 16'h8000, 16'hFFFF));
    send_item(OP_VERT, vert_data(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
    send_item(OP_VERT, vert_data(0, 0, 0, 16'h1234, 16'h5678, 16'h9ABC));
    send_item(OP_TRI, tri_data(0, 1, 3));
    send_item(OP_TRI, tri_data(0, 2, 1));
    send_item(OP_TRI, tri_data(3, 1, 4));
    send_item(OP_TRI, tri_data(10'h3FF, 0, 1));
    send_item(OP_NONE, vert_data(1, 2, 3, 4, 5, 6));
    send_item(OP_CLEAR, '1);
    send_item(OP_TRI, tri_data(0, 0, 0));
  endtask

  task automatic test_weld_tolerance(logic [30:0] d);
    write_weld_distance(d);
    send_item(OP_CLEAR, '0);
    send_item(OP_VERT, vert_data(0, 0, 0, 1, 2, 3));
    send_item(OP_VERT, vert_data({1'b0, d}, 0, 0, 4, 5, 6));
    send_item(OP_VERT, vert_data(0, {1'b0, d} + 1, 0, 7, 8, 9));
    send_item(OP_VERT, vert_data(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1));
    send_item(OP_TRI, tri_data(0, 2, 3));
    send_item(OP_TRI, tri_data(1, 2, 3));
  endtask

  task automatic test_random_meshes(int count, int coord_mode);
    int n;
    n = 0;
    while (n < count) begin
      int verts;
      send_item(OP_CLEAR, '0); n++;
      verts = $urandom_range(1, 12);
      for (int v = 0; v < verts; v++) begin
        send_item(OP_VERT, vert_data(rnd_coord(coord_mode), rnd_coord(coord_mode),
                                     rnd_coord(coord_mode), 16'($urandom), 16'($urandom),
                                     16'($urandom)));
        n++;
      end
      repeat ($urandom_range(1, 10)) begin
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) send_item(OP_NONE, 176'({6{$urandom}}));
        else if (r < 3) begin
          send_item(OP_TRI, tri_data(10'($urandom), 10'($urandom_range(0, verts)),
                                     10'($urandom_range(0, verts))));
          n++;
        end else begin
          send_item(OP_TRI, tri_data(10'($urandom_range(0, verts - 1)),
                                     10'($urandom_range(0, verts - 1)),
                                     10'($urandom_range(0, verts - 1))));
          n++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_off = 1;
    no_gaps = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      begin
        send_item(OP_CLEAR, '0);
        for (int v = 0; v < 6; v++)
          send_item(OP_VERT, vert_data($urandom, $urandom, $urandom, 16'($urandom),
                                       16'($urandom), 16'($urandom)));
        for (int t = 0; t < 6; t++)
          send_item(OP_TRI, tri_data(10'(t), 10'(t + 1 - (t / 5) * 6), 10'd0));
      end
    join
    no_gaps = 0;
  endtask

  initial begin
    mesh_loaded = 0;
    mesh_unique = 0;
    weld_dist = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_directed();
    test_weld_tolerance(31'h0001_0000);
    test_weld_tolerance(31'h7FFF_FFFF);
    write_weld_distance(31'h0000_4000);
    test_random_meshes(200, 1);
    write_weld_distance(31'h0001_8000);
    test_random_meshes(150, 1);
    write_weld_distance(31'h5555_AAAA);
    test_random_meshes(80, 0);
    write_weld_distance(31'h7FFF_FFFF);
    test_random_meshes(60, 2);
    test_backpressure();
    drain();
    if (errors == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #60000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
